FILE: design/bxds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_pkg
// Shared constants and types for the box average downsampler.
// ----------------------------------------------------------------------------
package bxds_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int MAX_LOG2     = 4;

    localparam int PIX_W   = 8;
    localparam int NUM_CH  = 3;
    localparam int SIZE_W  = 12;
    localparam int LOG2_W  = 3;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
    localparam int MASK_W  = MAX_LOG2;
    // one tile row holds at most 2^MAX_LOG2 pixels, a tile 2^(2*MAX_LOG2)
    localparam int RUN_W   = PIX_W + MAX_LOG2;
    localparam int SUM_W   = PIX_W + 2 * MAX_LOG2;
    localparam int WORD_W  = NUM_CH * SUM_W;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] CFG_LOG2   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [LOG2_W-1:0] LOG2_RESET   = 3'd1;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

    // tile-column event handed from the front end to the accumulate stage
    typedef struct packed {
        logic                             first_row;
        logic                             emit;
        logic                             last;
        logic [LOG2_W-1:0]                shift;
        logic [COL_W-1:0]                 col;
        logic [ROW_W-1:0]                 orow;
        logic [NUM_CH-1:0][RUN_W-1:0]     run;
    } bxds_item_t;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] bxds_sums_t;

endpackage

FILE: design/bxds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module bxds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/bxds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_front
// Configuration registers, pixel position counters and row running sums.
// Detects the last pixel of each tile row and issues the column sum read.
// ----------------------------------------------------------------------------
module bxds_front
    import bxds_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CIDX_W-1:0]              cfg_index,
    input  logic [SIZE_W-1:0]              cfg_data,
    input  logic                           accept,
    input  logic [NUM_CH-1:0][PIX_W-1:0]   pixel,
    output logic                           item_valid,
    output bxds_item_t                     item
);

    logic [LOG2_W-1:0]            log2_reg;
    logic [SIZE_W-1:0]            width_reg;
    logic [SIZE_W-1:0]            height_reg;
    logic [COL_W-1:0]             pixel_x_reg;
    logic [ROW_W-1:0]             pixel_y_reg;
    logic [NUM_CH-1:0][RUN_W-1:0] run_reg;

    logic [COL_W-1:0]             pixel_x_next;
    logic [ROW_W-1:0]             pixel_y_next;
    logic [NUM_CH-1:0][RUN_W-1:0] run_next;

    logic [LOG2_W-1:0] k_eff;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] xm;
    logic [MASK_W-1:0] ym;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  orow;
    logic [SIZE_W-1:0] x_inc;
    logic [SIZE_W-1:0] y_inc;
    logic              hit;
    logic              cfg_hit;

    always_comb
    begin
        k_eff = (log2_reg > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : log2_reg;

        if (width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(HEIGHT_LIMIT))
            h_eff = SIZE_W'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;

        mask = MASK_W'((MASK_W + 1)'(1) << k_eff) - MASK_W'(1);
        xm   = pixel_x_reg[MASK_W-1:0] & mask;
        ym   = pixel_y_reg[MASK_W-1:0] & mask;
        cols = w_eff >> k_eff;
        rows = h_eff >> k_eff;
        col  = pixel_x_reg >> k_eff;
        orow = pixel_y_reg >> k_eff;
        hit  = (xm == mask) && ({1'b0, col} < cols);

        for (int c = 0; c < NUM_CH; c++)
        begin
            if (xm == '0)
                run_next[c] = RUN_W'(pixel[c]);
            else
                run_next[c] = run_reg[c] + RUN_W'(pixel[c]);
        end

        x_inc = {1'b0, pixel_x_reg} + SIZE_W'(1);
        y_inc = {1'b0, pixel_y_reg} + SIZE_W'(1);
        if (x_inc >= w_eff)
        begin
            pixel_x_next = '0;
            pixel_y_next = (y_inc >= h_eff) ? '0 : y_inc[ROW_W-1:0];
        end
        else
        begin
            pixel_x_next = x_inc[COL_W-1:0];
            pixel_y_next = pixel_y_reg;
        end

        item.first_row = (ym == '0);
        item.emit      = (ym == mask) && ({1'b0, orow} < rows);
        item.last      = ({1'b0, col} == cols - SIZE_W'(1))
                         && ({1'b0, orow} == rows - SIZE_W'(1));
        item.shift     = k_eff;
        item.col       = col;
        item.orow      = orow;
        item.run       = run_next;
        item_valid     = accept && hit;
    end

    assign cfg_hit = cfg_we && ((cfg_index == CFG_LOG2) || (cfg_index == CFG_WIDTH)
                                || (cfg_index == CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg    <= LOG2_RESET;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pixel_x_reg <= '0;
            pixel_y_reg <= '0;
            run_reg     <= '0;
        end
        else if (cfg_hit)
        begin
            // any register write restarts the frame
            case (cfg_index)
                CFG_LOG2:   log2_reg   <= cfg_data[LOG2_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
            pixel_x_reg <= '0;
            pixel_y_reg <= '0;
            run_reg     <= '0;
        end
        else if (accept)
        begin
            pixel_x_reg <= pixel_x_next;
            pixel_y_reg <= pixel_y_next;
            run_reg     <= run_next;
        end
    end

endmodule

FILE: design/bxds_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxds_accum
// Adds the tile row sum into the column sum, writes it back and forms the
// averaged output pixel in the output register.
// ----------------------------------------------------------------------------
module bxds_accum
    import bxds_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  bxds_item_t                    in_item,
    output logic                          in_ready,
    input  bxds_sums_t                    rd_data,
    output logic                          wr_en,
    output logic [COL_W-1:0]              wr_addr,
    output bxds_sums_t                    wr_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [NUM_CH-1:0][PIX_W-1:0]  out_pixel,
    output logic [COL_W-1:0]              out_col,
    output logic [ROW_W-1:0]              out_row,
    output logic                          out_last
);

    logic                         s1_valid_reg;
    bxds_item_t                   s1_item_reg;
    logic                         s1_fwd_reg;
    bxds_sums_t                   s1_fwd_data_reg;
    logic                         out_valid_reg;
    logic [NUM_CH-1:0][PIX_W-1:0] out_pixel_reg;
    logic [COL_W-1:0]             out_col_reg;
    logic [ROW_W-1:0]             out_row_reg;
    logic                         out_last_reg;

    logic                         s1_adv;
    logic                         s1_load;
    logic                         out_load;
    bxds_sums_t                   sum;
    bxds_sums_t                   base;
    logic [NUM_CH-1:0][PIX_W-1:0] avg;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign s1_load  = in_valid && in_ready;
    assign wr_en    = s1_valid_reg && s1_adv;
    assign wr_addr  = s1_item_reg.col;
    assign wr_data  = sum;
    assign out_load = wr_en && s1_item_reg.emit;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            // the read was issued in the same cycle as a write to that column
            if (s1_item_reg.first_row)
                base[c] = '0;
            else if (s1_fwd_reg)
                base[c] = s1_fwd_data_reg[c];
            else
                base[c] = rd_data[c];
            sum[c] = base[c] + SUM_W'(s1_item_reg.run[c]);
            avg[c] = PIX_W'(sum[c] >> {s1_item_reg.shift, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= wr_en && (wr_addr == in_item.col);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg     <= in_item;
            s1_fwd_data_reg <= sum;
        end
        if (out_load)
        begin
            out_pixel_reg <= avg;
            out_col_reg   <= s1_item_reg.col;
            out_row_reg   <= s1_item_reg.orow;
            out_last_reg  <= s1_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_last  = out_last_reg;

    // a tile event is never taken while the stage holds a stalled one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (!s1_valid_reg || s1_adv))
        else $error("tile event entered a stalled stage");

    // a stalled stage keeps its event until the output frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stalled tile event lost");

    // a held result is not overwritten by the next tile
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            (out_valid_reg && $stable(out_pixel_reg) && $stable(out_col_reg)
             && $stable(out_row_reg)))
        else $error("held result overwritten");

    // forwarding only follows a write-back in the cycle the item came in
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> (s1_fwd_reg == $past(wr_en && (wr_addr == in_item.col))))
        else $error("column forward flag mismatch");

endmodule

FILE: design/box_average_downsampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downsampler_core
// Power-of-two box filter downsampler for an RGB raster pixel stream.
// Result path: the tile's last pixel event is registered in the accumulate stage,
// then the averaged result in the output register that drives m_axis_tvalid.
// Throughput: one pixel per cycle unless the output stalls; the column sum RAM does
// one read and one write per cycle, with write-to-read forwarding for back-to-back tile columns.
// Reset: position, row sums and output clear; registers load factor 2, 640x480.
// The column sum RAM is not cleared: the first row of each tile band overwrites it.
// ----------------------------------------------------------------------------
module box_average_downsampler_core
    import bxds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // red_in, green_in, blue_in
    input  logic [23:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // red_avg, green_avg, blue_avg, out_column, out_row, zero fill
    output logic [47:0]       m_axis_tdata,
    // frame_end
    output logic              m_axis_tlast
);

    logic                         accept;
    logic                         item_valid;
    bxds_item_t                   item;
    logic                         in_ready;
    logic [NUM_CH-1:0][PIX_W-1:0] pixel;
    bxds_sums_t                   rd_data;
    logic                         wr_en;
    logic [COL_W-1:0]             wr_addr;
    bxds_sums_t                   wr_data;
    logic [NUM_CH-1:0][PIX_W-1:0] out_pixel;
    logic [COL_W-1:0]             out_col;
    logic [ROW_W-1:0]             out_row;

    assign pixel         = s_axis_tdata;
    assign s_axis_tready = in_ready;
    assign accept        = s_axis_tvalid && in_ready;

    bxds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .pixel      (pixel),
        .item_valid (item_valid),
        .item       (item)
    );

    bxds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (item_valid),
        .rd_addr (item.col),
        .rd_data (rd_data)
    );

    bxds_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_item   (item),
        .in_ready  (in_ready),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (out_pixel),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_row, out_col, out_pixel};

endmodule
